/* hdl/swrs_pkg.sv */
package swrs_pkg;

  localparam int IDX_W  = 10;  // index fields of the input word
  localparam int DATA_W = 32;  // element value field
  localparam int POS_W  = 11;  // window edge, 0..1024
  localparam int CNT_W  = 11;  // element_count register
  localparam int SUM_W  = 42;  // running sum

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_QUERY,
    CMD_BAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [IDX_W-1:0]   addr;
    logic [DATA_W-1:0]  value;
    logic [IDX_W-1:0]   left;
    logic [IDX_W-1:0]   right;
  } cmd_t;

endpackage

/* hdl/sliding_window_range_sum_core.sv */
// Sliding-window range-sum engine.
// Input stream (in_*): one word per element load (tuser = 0) or range-sum
// query (tuser = 1). Loads write the element store and empty the window;
// they produce no output word. Each query produces exactly one output word.
// Output stream (out_*): tdata carries the 42-bit two's complement sum,
// tuser flags a rejected range (left > right or right >= element_count),
// which returns a zero sum and leaves the window untouched.
// cfg_*: writes element_count; only change it while the engine is idle.
// A load retires as soon as it reaches the back end, output stall or not; a
// rejected query as soon as the output register is free; a legal query first moves
// both window edges from the previous query's place to the new range, one element
// at a time, and skips that walk when both edges are already in place.
// One element is read from the single-port store per cycle, so that walk
// sets the throughput. The input side sees a two-word queue, so it keeps
// taking words, until the queue fills, while the back end walks or the output is stalled;
// a stalled output word holds in its register, and the back end holds its next result behind it.
// Reset (synchronous, rst_n low) empties the queue, the window and its sum
// and sets element_count to 0; the store itself is not cleared.
module sliding_window_range_sum_core import swrs_pkg::*; #(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             in_tvalid,
  output logic             in_tready,
  // [9:0] elem_addr, [41:10] elem_value, [51:42] query_left,
  // [61:52] query_right, [63:62] zero
  input  logic [63:0]      in_tdata,
  // [0] mode
  input  logic [0:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // [41:0] range_sum, [47:42] zero
  output logic [47:0]      out_tdata,
  // [0] query_error
  output logic [0:0]       out_tuser
);

  logic             q_full;
  logic             q_push;
  cmd_t             q_cmd;
  logic             q_pop;
  logic             head_vld;
  cmd_t             head;
  logic [SUM_W-1:0] sum;
  logic             err;

  swrs_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (in_tuser[0]),
    .in_addr   (in_tdata[9:0]),
    .in_value  (in_tdata[41:10]),
    .in_left   (in_tdata[51:42]),
    .in_right  (in_tdata[61:52]),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  swrs_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_vld (head_vld),
    .head     (head)
  );

  swrs_back #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_vld  (head_vld),
    .head      (head),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_sum   (sum),
    .out_err   (err)
  );

  assign out_tdata = {6'd0, sum};
  assign out_tuser = err;

endmodule

/* hdl/swrs_front.sv */
module swrs_front import swrs_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [IDX_W-1:0]  in_addr,
  input  logic [DATA_W-1:0] in_value,
  input  logic [IDX_W-1:0]  in_left,
  input  logic [IDX_W-1:0]  in_right,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_cmd
);

  logic [CNT_W-1:0] count_r;
  logic             bad_range;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign q_push    = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_valid) begin
      count_r <= cfg_data;
    end
  end

  // reject the query up front so the back end only ever walks legal ranges
  always_comb begin
    bad_range = (in_left > in_right)
             || ({1'b0, in_right} >= count_r)
             || (32'(in_right) >= 32'(DEPTH));
    q_cmd.addr  = in_addr;
    q_cmd.value = in_value;
    q_cmd.left  = in_left;
    q_cmd.right = in_right;
    if (!in_mode) begin
      q_cmd.kind = CMD_LOAD;
    end else if (bad_range) begin
      q_cmd.kind = CMD_BAD;
    end else begin
      q_cmd.kind = CMD_QUERY;
    end
  end

endmodule

/* hdl/swrs_fifo.sv */
module swrs_fifo import swrs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_vld,
  output cmd_t head
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;

  assign full     = (fill_r == 2'd2);
  assign head_vld = (fill_r != 2'd0);
  assign head     = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

endmodule

/* hdl/swrs_back.sv */
module swrs_back import swrs_pkg::*; #(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_vld,
  input  cmd_t             head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SUM_W-1:0] out_sum,
  output logic             out_err
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  logic [VALUE_BITS-1:0] mem [DEPTH];

  state_t                state_r, state_nxt;
  logic [POS_W-1:0]      start_r, start_nxt;
  logic [POS_W-1:0]      end_r, end_nxt;
  logic [SUM_W-1:0]      total_r, total_nxt;
  logic                  pend_r, pend_nxt;
  logic                  sub_r, sub_nxt;
  logic [VALUE_BITS-1:0] rd_data_r;
  logic                  out_vld_r, out_vld_nxt;
  logic [SUM_W-1:0]      out_sum_r, out_sum_nxt;
  logic                  out_err_r, out_err_nxt;

  logic [AW-1:0]         rd_addr;
  logic                  we;
  logic                  slot_free;
  logic [POS_W-1:0]      left_w;
  logic [POS_W-1:0]      stop_w;
  logic [SUM_W-1:0]      elem_ext;

  assign out_valid = out_vld_r;
  assign out_sum   = out_sum_r;
  assign out_err   = out_err_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[AW'(head.addr)] <= head.value[VALUE_BITS-1:0];
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    slot_free = !out_vld_r || out_ready;
    left_w    = {1'b0, head.left};
    stop_w    = {1'b0, head.right} + POS_W'(1);
    elem_ext  = SUM_W'(signed'(rd_data_r));

    state_nxt   = state_r;
    start_nxt   = start_r;
    end_nxt     = end_r;
    total_nxt   = total_r;
    pend_nxt    = 1'b0;
    sub_nxt     = sub_r;
    rd_addr     = AW'(start_r);
    we          = 1'b0;
    pop         = 1'b0;
    out_vld_nxt = out_vld_r && !out_ready;
    out_sum_nxt = out_sum_r;
    out_err_nxt = out_err_r;

    case (state_r)
      ST_IDLE: begin
        if (head_vld) begin
          case (head.kind)
            CMD_LOAD: begin
              we        = (32'(head.addr) < 32'(DEPTH));
              start_nxt = '0;
              end_nxt   = '0;
              total_nxt = '0;
              pop       = 1'b1;
            end
            CMD_BAD: begin
              if (slot_free) begin
                out_vld_nxt = 1'b1;
                out_sum_nxt = '0;
                out_err_nxt = 1'b1;
                pop         = 1'b1;
              end
            end
            CMD_QUERY: begin
              state_nxt = ST_WALK;
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        // add or subtract the word read last cycle while the next read goes out
        if (pend_r) begin
          total_nxt = sub_r ? (total_r - elem_ext) : (total_r + elem_ext);
        end
        if (start_r < left_w) begin
          rd_addr   = AW'(start_r);
          sub_nxt   = 1'b1;
          pend_nxt  = 1'b1;
          start_nxt = start_r + POS_W'(1);
        end else if (start_r > left_w) begin
          rd_addr   = AW'(start_r - POS_W'(1));
          sub_nxt   = 1'b0;
          pend_nxt  = 1'b1;
          start_nxt = start_r - POS_W'(1);
        end else if (end_r < stop_w) begin
          rd_addr  = AW'(end_r);
          sub_nxt  = 1'b0;
          pend_nxt = 1'b1;
          end_nxt  = end_r + POS_W'(1);
        end else if (end_r > stop_w) begin
          rd_addr  = AW'(end_r - POS_W'(1));
          sub_nxt  = 1'b1;
          pend_nxt = 1'b1;
          end_nxt  = end_r - POS_W'(1);
        end else if (!pend_r && slot_free) begin
          out_vld_nxt = 1'b1;
          out_sum_nxt = total_r;
          out_err_nxt = 1'b0;
          pop         = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      start_r   <= '0;
      end_r     <= '0;
      total_r   <= '0;
      pend_r    <= 1'b0;
      sub_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      start_r   <= start_nxt;
      end_r     <= end_nxt;
      total_r   <= total_nxt;
      pend_r    <= pend_nxt;
      sub_r     <= sub_nxt;
      out_vld_r <= out_vld_nxt;
    end
    out_sum_r <= out_sum_nxt;
    out_err_r <= out_err_nxt;
  end

endmodule
